/* src/kac_pkg.sv */
// ----------------------------------------------------------------------------
// kac_pkg: keypad alarm controller shared definitions
// Widths, register indexes, reset values, button slots and the request and
// result item types used by the interfaces and the top level.
// ----------------------------------------------------------------------------
package kac_pkg;

  localparam int CODE_BITS = 8;
  localparam int TIME_BITS = 48;
  localparam int REG_BITS  = 24;
  localparam int IDX_BITS  = 2;
  localparam int NUM_BTNS  = 5;
  localparam int BTN_BITS  = 3;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_DEBOUNCE = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_FLASH    = IDX_BITS'(1);

  localparam logic [REG_BITS-1:0] DEBOUNCE_RESET = REG_BITS'(250 * 1000);
  localparam logic [REG_BITS-1:0] FLASH_RESET    = REG_BITS'(200 * 1000);

  // slots of the per-button last-press times
  localparam logic [BTN_BITS-1:0] BTN_ARM    = BTN_BITS'(0);
  localparam logic [BTN_BITS-1:0] BTN_DISARM = BTN_BITS'(1);
  localparam logic [BTN_BITS-1:0] BTN_ZERO   = BTN_BITS'(2);
  localparam logic [BTN_BITS-1:0] BTN_ONE    = BTN_BITS'(3);
  localparam logic [BTN_BITS-1:0] BTN_SET    = BTN_BITS'(4);

  typedef struct packed {
    logic [TIME_BITS-1:0] time_us;
    logic                 arm_n;
    logic                 disarm_n;
    logic                 zero_n;
    logic                 one_n;
    logic                 setcode_n;
  } in_item_t;

  typedef struct packed {
    logic red_led;
    logic green_led;
    logic blue_led;
    logic armed;
    logic alarm_on;
  } out_item_t;

endpackage

/* src/kac_if.sv */
// ----------------------------------------------------------------------------
// kac_in_if / kac_out_if: valid/ready channels of the keypad alarm controller
// Poll request channel and LED status result channel.
// ----------------------------------------------------------------------------
interface kac_in_if;
  logic              valid;
  logic              ready;
  kac_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kac_out_if;
  logic               valid;
  logic               ready;
  kac_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/keypad_alarm_controller.sv */
// ----------------------------------------------------------------------------
// keypad_alarm_controller: two-button combination lock with flashing alarm
// Debounced arm, disarm, code entry and LED control from polled buttons.
// ----------------------------------------------------------------------------
// Each poll request (timestamp plus five active-low buttons) is captured in an
// input register, evaluated in one pass against the lock state, and its LED
// status lands in a result register; a new request is taken every cycle while
// the result side keeps up. The rate is one request per cycle, set by the single
// evaluation stage that updates the lock state, and holds while the result side
// keeps up. Debounce and flash times are compared on timestamp differences
// taken modulo 2^48. Write configuration only while no request is in flight.
module keypad_alarm_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  kac_in_if.sink                                in_i,
  kac_out_if.source                             out_o,
  input  logic                                  cfg_we_i,
  input  logic [kac_pkg::IDX_BITS-1:0]          cfg_idx_i,
  input  logic [kac_pkg::REG_BITS-1:0]          cfg_wdata_i
);

  localparam int TB = kac_pkg::TIME_BITS;
  localparam int CB = kac_pkg::CODE_BITS;
  localparam int NB = kac_pkg::NUM_BTNS;

  // configuration
  logic [kac_pkg::REG_BITS-1:0] debounce_q, flash_q;

  // handshake stages
  logic              s1_valid_q;
  kac_pkg::in_item_t s1_q;
  logic               out_valid_q;
  kac_pkg::out_item_t out_q, out_d;
  logic out_free, s1_fire, in_fire;

  // lock state
  logic          armed_q, armed_d;
  logic          trig_q, trig_d;
  logic          phase_q, phase_d;
  logic          setting_q, setting_d;
  logic [CB-1:0] stored_q, stored_d;
  logic [CB-1:0] entry_q, entry_d;
  logic [CB-1:0] guess_q, guess_d;
  logic          red_q, red_d;
  logic          green_q, green_d;
  logic [TB-1:0] beep_q, beep_d;
  logic [TB-1:0] lp_q [NB];
  logic [TB-1:0] lp_d [NB];

  // evaluation terms
  logic [TB-1:0] now;
  logic [NB-1:0] press, ok;
  logic          arm_acc, armed_a, dis_acc, match, armed_b, trig_b;
  logic [CB-1:0] guess_a, guess_b, guess_c, entry_b, entry_c;
  logic          set_start, setting_b, set_end;
  logic          zero_s, one_s, zero_g, one_g, beep_ok;

  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    now = s1_q.time_us;
    press[kac_pkg::BTN_ARM]    = !s1_q.arm_n;
    press[kac_pkg::BTN_DISARM] = !s1_q.disarm_n;
    press[kac_pkg::BTN_ZERO]   = !s1_q.zero_n;
    press[kac_pkg::BTN_ONE]    = !s1_q.one_n;
    press[kac_pkg::BTN_SET]    = !s1_q.setcode_n;
    for (int b = 0; b < NB; b++) begin
      ok[b] = TB'(now - lp_q[b]) > TB'(debounce_q);
    end

    // arm, then disarm with code check
    arm_acc = !armed_q && !setting_q && press[kac_pkg::BTN_ARM] && ok[kac_pkg::BTN_ARM];
    armed_a = armed_q || arm_acc;
    guess_a = arm_acc ? '0 : guess_q;
    dis_acc = armed_a && press[kac_pkg::BTN_DISARM] && ok[kac_pkg::BTN_DISARM];
    match   = guess_a == stored_q;
    armed_b = (dis_acc && match) ? 1'b0 : armed_a;
    trig_b  = dis_acc ? !match : trig_q;
    guess_b = (dis_acc && match) ? '0 : guess_a;

    // code setting; a set press that opens entry cannot also close it
    set_start = !armed_b && !setting_q && press[kac_pkg::BTN_SET] && ok[kac_pkg::BTN_SET];
    setting_b = setting_q || set_start;
    entry_b   = set_start ? '0 : entry_q;
    zero_s    = setting_b && press[kac_pkg::BTN_ZERO] && ok[kac_pkg::BTN_ZERO];
    one_s     = setting_b && press[kac_pkg::BTN_ONE] && ok[kac_pkg::BTN_ONE];
    entry_c   = zero_s ? CB'({entry_b, 1'b0}) : entry_b;
    entry_d   = one_s ? CB'({entry_c, 1'b1}) : entry_c;
    set_end   = setting_q && press[kac_pkg::BTN_SET] && ok[kac_pkg::BTN_SET];
    stored_d  = set_end ? entry_d : stored_q;
    setting_d = set_end ? 1'b0 : setting_b;

    // guess entry; a press already taken for the code does not count twice
    zero_g  = armed_b && press[kac_pkg::BTN_ZERO] && ok[kac_pkg::BTN_ZERO] && !zero_s;
    one_g   = armed_b && press[kac_pkg::BTN_ONE] && ok[kac_pkg::BTN_ONE] && !one_s;
    guess_c = zero_g ? CB'({guess_b, 1'b0}) : guess_b;
    guess_d = one_g ? CB'({guess_c, 1'b1}) : guess_c;

    lp_d[kac_pkg::BTN_ARM]    = arm_acc ? now : lp_q[kac_pkg::BTN_ARM];
    lp_d[kac_pkg::BTN_DISARM] = dis_acc ? now : lp_q[kac_pkg::BTN_DISARM];
    lp_d[kac_pkg::BTN_ZERO]   = (zero_s || zero_g) ? now : lp_q[kac_pkg::BTN_ZERO];
    lp_d[kac_pkg::BTN_ONE]    = (one_s || one_g) ? now : lp_q[kac_pkg::BTN_ONE];
    lp_d[kac_pkg::BTN_SET]    = (set_start || set_end) ? now : lp_q[kac_pkg::BTN_SET];

    armed_d = armed_b;
    trig_d  = trig_b;

    // LEDs: red flashes only while triggered, green holds its last level
    beep_ok = TB'(now - beep_q) > TB'(flash_q);
    phase_d = phase_q;
    red_d   = red_q;
    green_d = green_q;
    beep_d  = beep_q;
    if (!trig_b) begin
      red_d   = armed_b;
      green_d = !armed_b;
    end else if (beep_ok) begin
      phase_d = !phase_q;
      red_d   = !phase_q;
      beep_d  = now;
    end

    out_d.red_led   = red_d;
    out_d.green_led = green_d;
    out_d.blue_led  = setting_d;
    out_d.armed     = armed_d;
    out_d.alarm_on  = trig_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= kac_pkg::DEBOUNCE_RESET;
      flash_q    <= kac_pkg::FLASH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kac_pkg::REG_DEBOUNCE: debounce_q <= cfg_wdata_i;
        kac_pkg::REG_FLASH:    flash_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_i.data;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  // advance lock state once per evaluated request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      trig_q    <= 1'b0;
      phase_q   <= 1'b0;
      setting_q <= 1'b0;
      stored_q  <= '0;
      entry_q   <= '0;
      guess_q   <= '0;
      red_q     <= 1'b0;
      green_q   <= 1'b0;
      beep_q    <= '0;
      for (int b = 0; b < NB; b++) begin
        lp_q[b] <= '0;
      end
    end else if (s1_fire) begin
      armed_q   <= armed_d;
      trig_q    <= trig_d;
      phase_q   <= phase_d;
      setting_q <= setting_d;
      stored_q  <= stored_d;
      entry_q   <= entry_d;
      guess_q   <= guess_d;
      red_q     <= red_d;
      green_q   <= green_d;
      beep_q    <= beep_d;
      for (int b = 0; b < NB; b++) begin
        lp_q[b] <= lp_d[b];
      end
    end
  end

endmodule

/* tb/kac_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kac_checker: lock state predictor and LED status scoreboard
// Watches the poll and status channels and the register write port, keeps its
// own copy of the lock state and timing registers, predicts the LED status of
// every accepted poll request and compares each returned status field by field.
// ----------------------------------------------------------------------------
module kac_checker
  import kac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  kac_in_if                   poll_i,
  kac_out_if                  status_i,
  input  logic                cfg_we_i,
  input  logic [IDX_BITS-1:0] cfg_idx_i,
  input  logic [REG_BITS-1:0] cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int MAX_PRINTS = 60;

  logic [REG_BITS-1:0]  debounce_us;
  logic [REG_BITS-1:0]  flash_us;
  logic                 armed_q;
  logic                 alarm_q;
  logic                 phase_q;
  logic                 setting_q;
  logic                 red_q;
  logic                 green_q;
  logic [CODE_BITS-1:0] code_q;
  logic [CODE_BITS-1:0] entry_q;
  logic [CODE_BITS-1:0] guess_q;
  logic [TIME_BITS-1:0] beep_time_q;
  logic [TIME_BITS-1:0] press_time_q [NUM_BTNS];

  out_item_t expected_status_q [$];
  int        mismatches = 0;
  int        statuses_seen = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(string msg);
    mismatches++;
    // keep the log short on a badly broken block, but keep counting
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] status %0d: %s", $time, statuses_seen, msg);
    end
  endtask

  // debounce: accept and stamp only when strictly more than the window passed
  function automatic logic press_ok(logic [BTN_BITS-1:0] btn, logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] elapsed;
    elapsed = now - press_time_q[btn];
    if (elapsed > TIME_BITS'(debounce_us)) begin
      press_time_q[btn] = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_status(in_item_t req);
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] since_beep;
    logic                 arm_p;
    logic                 disarm_p;
    logic                 zero_p;
    logic                 one_p;
    logic                 set_p;
    out_item_t            res;
    now      = req.time_us;
    arm_p    = !req.arm_n;
    disarm_p = !req.disarm_n;
    zero_p   = !req.zero_n;
    one_p    = !req.one_n;
    set_p    = !req.setcode_n;

    if (!armed_q && !setting_q && arm_p) begin
      if (press_ok(BTN_ARM, now)) begin
        armed_q = 1'b1;
        guess_q = '0;
      end
    end
    if (armed_q && disarm_p) begin
      if (press_ok(BTN_DISARM, now)) begin
        if (guess_q == code_q) begin
          armed_q = 1'b0;
          alarm_q = 1'b0;
          guess_q = '0;
        end else begin
          alarm_q = 1'b1;
        end
      end
    end

    if (!armed_q && !setting_q && set_p) begin
      if (press_ok(BTN_SET, now)) begin
        setting_q = 1'b1;
        entry_q   = '0;
      end
    end
    if (setting_q && zero_p) begin
      if (press_ok(BTN_ZERO, now)) entry_q = {entry_q[CODE_BITS-2:0], 1'b0};
    end
    if (setting_q && one_p) begin
      if (press_ok(BTN_ONE, now)) entry_q = {entry_q[CODE_BITS-2:0], 1'b1};
    end
    if (setting_q && set_p) begin
      if (press_ok(BTN_SET, now)) begin
        code_q    = entry_q;
        setting_q = 1'b0;
      end
    end

    if (armed_q) begin
      if (zero_p) begin
        if (press_ok(BTN_ZERO, now)) guess_q = {guess_q[CODE_BITS-2:0], 1'b0};
      end
      if (one_p) begin
        if (press_ok(BTN_ONE, now)) guess_q = {guess_q[CODE_BITS-2:0], 1'b1};
      end
    end

    // while triggered, green holds and red follows the flash phase
    since_beep = now - beep_time_q;
    if (!alarm_q) begin
      red_q   = armed_q;
      green_q = !armed_q;
    end else if (since_beep > TIME_BITS'(flash_us)) begin
      phase_q     = !phase_q;
      red_q       = phase_q;
      beep_time_q = now;
    end

    res.red_led   = red_q;
    res.green_led = green_q;
    res.blue_led  = setting_q;
    res.armed     = armed_q;
    res.alarm_on  = alarm_q;
    return res;
  endfunction

  task automatic check_field(string name, logic got, logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %b, predicted %b", name, got, want));
    end
  endtask

  task automatic check_status(out_item_t got);
    out_item_t want;
    statuses_seen++;
    if (expected_status_q.size() == 0) begin
      report_mismatch($sformatf("status %b arrived with no request pending", got));
      return;
    end
    want = expected_status_q.pop_front();
    check_field("red_led", got.red_led, want.red_led);
    check_field("green_led", got.green_led, want.green_led);
    check_field("blue_led", got.blue_led, want.blue_led);
    check_field("armed", got.armed, want.armed);
    check_field("alarm_on", got.alarm_on, want.alarm_on);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_us = DEBOUNCE_RESET;
      flash_us    = FLASH_RESET;
      armed_q     = 1'b0;
      alarm_q     = 1'b0;
      phase_q     = 1'b0;
      setting_q   = 1'b0;
      red_q       = 1'b0;
      green_q     = 1'b0;
      code_q      = '0;
      entry_q     = '0;
      guess_q     = '0;
      beep_time_q = '0;
      foreach (press_time_q[b]) press_time_q[b] = '0;
      expected_status_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE: debounce_us = cfg_wdata_i;
          REG_FLASH:    flash_us = cfg_wdata_i;
          default: ;
        endcase
      end
      if (poll_i.valid && poll_i.ready) begin
        expected_status_q.push_back(predict_status(poll_i.data));
      end
      if (status_i.valid && status_i.ready) begin
        check_status(status_i.data);
      end
      pending_o <= expected_status_q.size();
    end
  end

endmodule

/* tb/keypad_alarm_controller_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_alarm_controller_tb: keypad alarm controller regression
// Drives poll requests from a running microsecond clock: a directed walk
// through debounce edges, code setting, wrong and right disarm, flashing and
// timestamp wrap, then random code, guess and noise sequences over several
// timing settings and idle patterns. A checker beside the block scores every
// LED status.
// ----------------------------------------------------------------------------
module keypad_alarm_controller_tb;
  import kac_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_POLLS  = 200;
  localparam int DRAIN_CYCLES = 4;

  // button press masks, pressed = 1
  localparam logic [NUM_BTNS-1:0] PRESS_NONE   = 5'b00000;
  localparam logic [NUM_BTNS-1:0] PRESS_ARM    = 5'b10000;
  localparam logic [NUM_BTNS-1:0] PRESS_DISARM = 5'b01000;
  localparam logic [NUM_BTNS-1:0] PRESS_ZERO   = 5'b00100;
  localparam logic [NUM_BTNS-1:0] PRESS_ONE    = 5'b00010;
  localparam logic [NUM_BTNS-1:0] PRESS_SET    = 5'b00001;
  localparam logic [NUM_BTNS-1:0] PRESS_ALL    = 5'b11111;

  // indexes with no register behind them
  localparam logic [IDX_BITS-1:0] REG_SPARE_A = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] REG_SPARE_B = IDX_BITS'(3);

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [IDX_BITS-1:0] cfg_idx;
  logic [REG_BITS-1:0] cfg_wdata;
  int                  fail_count;
  int                  pending;

  logic [TIME_BITS-1:0] now_us;
  logic [REG_BITS-1:0]  cur_debounce;
  logic [REG_BITS-1:0]  cur_flash;
  logic [CODE_BITS-1:0] code_shadow;
  int                   src_idle_pct;
  int                   snk_stall_pct;
  int                   polls_sent;
  int                   cycle_cnt;

  kac_in_if  poll_if ();
  kac_out_if status_if ();

  keypad_alarm_controller i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (poll_if),
    .out_o       (status_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  kac_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .poll_i       (poll_if),
    .status_i     (status_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    status_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_poll(logic [NUM_BTNS-1:0] pressed);
    in_item_t item;
    item.time_us   = now_us;
    item.arm_n     = !pressed[4];
    item.disarm_n  = !pressed[3];
    item.zero_n    = !pressed[2];
    item.one_n     = !pressed[1];
    item.setcode_n = !pressed[0];
    while ($urandom_range(0, 99) < src_idle_pct) begin
      poll_if.valid <= 1'b0;
      @(posedge clk);
    end
    poll_if.valid <= 1'b1;
    poll_if.data  <= item;
    @(posedge clk);
    while (!poll_if.ready) @(posedge clk);
    polls_sent++;
  endtask

  task automatic poll_at(logic [TIME_BITS-1:0] t, logic [NUM_BTNS-1:0] pressed);
    now_us = t;
    send_poll(pressed);
  endtask

  task automatic poll_after(logic [TIME_BITS-1:0] gap, logic [NUM_BTNS-1:0] pressed);
    now_us = now_us + gap;
    send_poll(pressed);
  endtask

  // mostly just past the debounce window, sometimes on it or inside it
  function automatic logic [TIME_BITS-1:0] pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return TIME_BITS'(cur_debounce) + 1 + TIME_BITS'($urandom_range(0, 3));
    if (r < 88) return TIME_BITS'(cur_debounce);
    if (r < 96) return TIME_BITS'($urandom_range(0, cur_debounce));
    return '0;
  endfunction

  task automatic wait_drained();
    poll_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [REG_BITS-1:0] deb, logic [REG_BITS-1:0] flash);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_idx   <= REG_FLASH;
    cfg_wdata <= flash;
    @(posedge clk);
    // writes to unused indexes must not disturb anything
    cfg_idx   <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_wdata <= REG_BITS'($urandom);
    @(posedge clk);
    cfg_we       <= 1'b0;
    cur_debounce = deb;
    cur_flash    = flash;
  endtask

  task automatic set_code_seq();
    int          nbits;
    int unsigned r;
    nbits = $urandom_range(0, 10);
    code_shadow = '0;
    poll_after(pick_gap(), PRESS_SET);
    for (int i = 0; i < nbits; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) begin
        // zero then one in the same request
        poll_after(pick_gap(), PRESS_ZERO | PRESS_ONE);
        code_shadow = {code_shadow[CODE_BITS-3:0], 2'b01};
      end else if (r[0]) begin
        poll_after(pick_gap(), PRESS_ONE);
        code_shadow = {code_shadow[CODE_BITS-2:0], 1'b1};
      end else begin
        poll_after(pick_gap(), PRESS_ZERO);
        code_shadow = {code_shadow[CODE_BITS-2:0], 1'b0};
      end
    end
    poll_after(pick_gap(), PRESS_SET);
  endtask

  task automatic enter_guess(logic [CODE_BITS-1:0] g);
    for (int i = CODE_BITS - 1; i >= 0; i--) begin
      poll_after(pick_gap(), g[i] ? PRESS_ONE : PRESS_ZERO);
    end
    poll_after(pick_gap(), PRESS_DISARM);
  endtask

  task automatic guess_seq();
    logic [CODE_BITS-1:0] g;
    int                   waits;
    int unsigned          r;
    poll_after(pick_gap(), PRESS_ARM);
    g = $urandom_range(0, 1) ? code_shadow : CODE_BITS'($urandom);
    enter_guess(g);
    // let the alarm flash for a few polls around the flash period
    waits = $urandom_range(0, 4);
    for (int i = 0; i < waits; i++) begin
      r = $urandom_range(0, 3);
      case (r)
        0: poll_after(TIME_BITS'(cur_flash), PRESS_NONE);
        1: poll_after(TIME_BITS'(cur_flash) + 1, PRESS_NONE);
        2: poll_after(TIME_BITS'(cur_flash / 2), PRESS_NONE);
        default: poll_after(TIME_BITS'($urandom_range(0, cur_flash + 2)), PRESS_NONE);
      endcase
    end
    if ($urandom_range(0, 1)) enter_guess(code_shadow);
  endtask

  task automatic noise_seq();
    int          n;
    int unsigned r;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      case (r)
        0: now_us = now_us - TIME_BITS'($urandom_range(1, 5000));
        1: now_us = TIME_MAX - TIME_BITS'($urandom_range(0, 1000));
        2: now_us = TIME_BITS'({$urandom, $urandom});
        default: now_us = now_us + pick_gap();
      endcase
      send_poll(NUM_BTNS'($urandom));
    end
  endtask

  initial begin
    int unsigned r;
    int          mid_mark;
    int          stop_mark;
    bit          drained_mid;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_DEBOUNCE;
    cfg_wdata       = '0;
    poll_if.valid   = 1'b0;
    poll_if.data    = '1;
    status_if.ready = 1'b0;
    now_us          = '0;
    cur_debounce    = DEBOUNCE_RESET;
    cur_flash       = FLASH_RESET;
    code_shadow     = '0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    polls_sent      = 0;
    cycle_cnt       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk at the reset timing values
    poll_at(48'd0, PRESS_NONE);
    poll_at(48'd250000, PRESS_ARM);                // exactly on the window: rejected
    poll_at(48'd250001, PRESS_ARM);                // armed
    poll_at(48'd500002, PRESS_DISARM);             // empty guess matches empty code
    poll_at(48'd750003, PRESS_SET);                // opens code entry
    poll_at(48'd1000004, PRESS_ZERO | PRESS_ONE);  // zero then one
    poll_at(48'd1250005, PRESS_ONE);
    poll_at(48'd1500006, PRESS_SET | PRESS_ARM);   // store, arm ignored while setting
    poll_at(48'd1750007, PRESS_ARM);
    poll_at(48'd2000008, PRESS_ONE);
    poll_at(48'd2250009, PRESS_DISARM);            // wrong code: trigger
    poll_at(48'd2450009, PRESS_NONE);              // flash period exactly: hold
    poll_at(48'd2450010, PRESS_NONE);              // toggle
    poll_at(48'd2700011, PRESS_ONE);
    poll_at(48'd2950012, PRESS_DISARM);            // right code, flash phase kept
    poll_at(TIME_MAX, PRESS_NONE);
    poll_at(TIME_MAX, PRESS_ALL);
    poll_at(48'd250000, PRESS_ONE);                // timestamp wraps
    poll_at(48'd500001, PRESS_DISARM);
    poll_at(48'd1000, PRESS_SET);                  // timestamp moves back
    poll_at(48'd1000, PRESS_ZERO);
    poll_at(48'd1000, PRESS_SET);                  // zero elapsed: rejected
    poll_at(48'd260001, PRESS_SET);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 65; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 65; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      case (p)
        0: ;
        1: configure('0, '0);
        2: configure('1, '1);
        3: configure(REG_BITS'($urandom_range(1, 40)), REG_BITS'($urandom_range(1, 60)));
        4: configure(REG_BITS'($urandom_range(1, 40)), '1);
        5: configure(REG_BITS'($urandom), REG_BITS'($urandom));
        6: configure('1, '0);
        default: configure(REG_BITS'($urandom_range(0, 8)), REG_BITS'($urandom_range(0, 8)));
      endcase
      mid_mark    = polls_sent + PHASE_POLLS / 2;
      stop_mark   = polls_sent + PHASE_POLLS;
      drained_mid = 1'b0;
      while (polls_sent < stop_mark) begin
        r = $urandom_range(0, 9);
        if (r < 4) set_code_seq();
        else if (r < 8) guess_seq();
        else noise_seq();
        // hold off mid-phase until every status is back
        if (!drained_mid && polls_sent >= mid_mark) begin
          wait_drained();
          drained_mid = 1'b1;
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
